// File: rtl/base64_stream_decoder_unit_assert.svh
// Assertion macros shared by the decoder modules.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

`define B64D_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

  localparam int CountBits = 24;
  localparam int CountW    = 24;
  localparam int LimitW    = 24;
  localparam int CmpW      = ((CountBits + 1) > LimitW) ? (CountBits + 1) : LimitW;

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [LimitW-1:0]    LimitReset = '1;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] ChDigit0  = 8'h30;
  localparam logic [7:0] ChDigit9  = 8'h39;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSlash   = 8'h2F;

  localparam logic [5:0] SxLower = 6'd26;
  localparam logic [5:0] SxDigit = 6'd52;
  localparam logic [5:0] SxPlus  = 6'd62;
  localparam logic [5:0] SxSlash = 6'd63;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StLone    = 2'd2,
    StLimit   = 2'd3
  } b64d_status_t;

  typedef struct packed {
    logic              hit;
    logic [5:0]        value;
  } b64d_sextet_t;

  typedef struct packed {
    logic [1:0]        nbytes;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [7:0]        byte2;
    logic              has_status;
    b64d_status_t      status;
    logic [CountW-1:0] count;
  } b64d_bundle_t;

  function automatic b64d_sextet_t sextet_of(logic [7:0] c);
    b64d_sextet_t s;
    s.hit   = 1'b1;
    s.value = '0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      s.value = 6'(c - ChUpperA);
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      s.value = 6'(c - ChLowerA) + SxLower;
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      s.value = 6'(c - ChDigit0) + SxDigit;
    end else if (c == ChPlus) begin
      s.value = SxPlus;
    end else if (c == ChSlash) begin
      s.value = SxSlash;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  function automatic logic limit_hit(logic [CountBits-1:0] cnt, logic [1:0] n,
                                     logic [LimitW-1:0] lim);
    logic [CmpW-1:0] nxt;
    nxt = CmpW'(cnt) + CmpW'(n);
    return (nxt > CmpW'(lim)) || (nxt > CmpW'(CountMax));
  endfunction

endpackage
`default_nettype wire

// File: rtl/b64d_decode.sv
`default_nettype none
`include "base64_stream_decoder_unit_assert.svh"
module b64d_decode (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_symbol,
  input  wire logic                         in_end_of_text,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [b64d_pkg::LimitW-1:0]  cfg_data,
  output logic                              bnd_valid,
  output b64d_pkg::b64d_bundle_t            bnd,
  input  wire logic                         bnd_ready
);
  import b64d_pkg::*;

  logic                 a_valid_r, a_valid_nxt;
  logic [7:0]           a_sym_r;
  logic                 a_eot_r;
  logic [17:0]          pg_r, pg_nxt;
  logic [1:0]           fill_r, fill_nxt;
  logic                 pad_r, pad_nxt;
  b64d_status_t         err_r, err_nxt;
  logic [CountBits-1:0] cnt_r, cnt_nxt;
  logic [LimitW-1:0]    limit_r;

  b64d_sextet_t         sx;
  logic [17:0]          e_pg;
  logic [1:0]           e_fill;
  logic                 e_pad;
  b64d_status_t         e_err;
  logic [CountBits-1:0] e_cnt;
  logic                 nonempty;
  logic                 adv;

  assign cfg_ready = 1'b1;

  always_comb begin
    sx              = sextet_of(a_sym_r);
    e_pg            = pg_r;
    e_fill          = fill_r;
    e_pad           = pad_r;
    e_err           = err_r;
    e_cnt           = cnt_r;
    bnd             = '0;
    bnd.status      = StOk;
    if (err_r == StOk) begin
      if (a_sym_r == PadChar) begin
        e_pad = 1'b1;
      end else if (pad_r || !sx.hit) begin
        e_err = StInvalid;
      end else if (fill_r == 2'd3) begin
        if (limit_hit(cnt_r, 2'd3, limit_r)) begin
          e_err = StLimit;
        end else begin
          bnd.nbytes = 2'd3;
          bnd.byte0  = pg_r[17:10];
          bnd.byte1  = pg_r[9:2];
          bnd.byte2  = {pg_r[1:0], sx.value};
          e_cnt      = cnt_r + CountBits'(3);
        end
        e_pg   = '0;
        e_fill = '0;
      end else begin
        e_pg   = {pg_r[11:0], sx.value};
        e_fill = fill_r + 2'd1;
      end
    end
    if (a_eot_r) begin
      if (e_err == StOk) begin
        unique case (e_fill)
          2'd0: begin
          end
          2'd1: e_err = StLone;
          2'd2: begin
            if (limit_hit(e_cnt, 2'd1, limit_r)) begin
              e_err = StLimit;
            end else begin
              bnd.nbytes = 2'd1;
              bnd.byte0  = e_pg[11:4];
              e_cnt      = e_cnt + CountBits'(1);
            end
          end
          2'd3: begin
            if (limit_hit(e_cnt, 2'd2, limit_r)) begin
              e_err = StLimit;
            end else begin
              bnd.nbytes = 2'd2;
              bnd.byte0  = e_pg[17:10];
              bnd.byte1  = e_pg[9:2];
              e_cnt      = e_cnt + CountBits'(2);
            end
          end
        endcase
      end
      bnd.has_status = 1'b1;
      bnd.status     = e_err;
      bnd.count      = CountW'(e_cnt);
    end
  end

  assign nonempty  = (bnd.nbytes != 2'd0) || bnd.has_status;
  assign bnd_valid = a_valid_r && nonempty;
  assign adv       = a_valid_r && (!nonempty || bnd_ready);
  assign in_ready  = !a_valid_r || adv;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_valid && in_ready) begin
      a_valid_nxt = 1'b1;
    end else if (adv) begin
      a_valid_nxt = 1'b0;
    end
    pg_nxt   = pg_r;
    fill_nxt = fill_r;
    pad_nxt  = pad_r;
    err_nxt  = err_r;
    cnt_nxt  = cnt_r;
    if (adv) begin
      if (a_eot_r) begin
        pg_nxt   = '0;
        fill_nxt = '0;
        pad_nxt  = 1'b0;
        err_nxt  = StOk;
        cnt_nxt  = '0;
      end else begin
        pg_nxt   = e_pg;
        fill_nxt = e_fill;
        pad_nxt  = e_pad;
        err_nxt  = e_err;
        cnt_nxt  = e_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      pg_r      <= '0;
      fill_r    <= '0;
      pad_r     <= 1'b0;
      err_r     <= StOk;
      cnt_r     <= '0;
      limit_r   <= LimitReset;
    end else begin
      a_valid_r <= a_valid_nxt;
      pg_r      <= pg_nxt;
      fill_r    <= fill_nxt;
      pad_r     <= pad_nxt;
      err_r     <= err_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_sym_r <= in_symbol;
      a_eot_r <= in_end_of_text;
    end
  end

  `B64D_ASSERT_NEXT(a_end_clears_state, adv && a_eot_r, fill_r == 2'd0 && err_r == StOk && cnt_r == '0 && !pad_r, "message state not cleared after end request")
  `B64D_ASSERT_HOLDS(a_stall_only_on_results, !(a_valid_r && !adv) || (nonempty && !bnd_ready), "decode stage held without a pending result")

endmodule
`default_nettype wire

// File: rtl/b64d_serializer.sv
`default_nettype none
`include "base64_stream_decoder_unit_assert.svh"
module b64d_serializer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        bnd_valid,
  input  wire b64d_pkg::b64d_bundle_t      bnd,
  output logic                             bnd_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_data_byte,
  output logic                             out_is_status,
  output logic [1:0]                       out_status,
  output logic [b64d_pkg::CountW-1:0]      out_byte_count,
  output logic                             out_final_item
);
  import b64d_pkg::*;

  b64d_bundle_t      bnd_r;
  logic              bnd_valid_r, bnd_valid_nxt;
  logic [1:0]        ptr_r, ptr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        data_r;
  logic              is_status_r;
  b64d_status_t      status_r;
  logic [CountW-1:0] count_r;

  logic [2:0]        total;
  logic [2:0]        ptr_ext;
  logic              pop;
  logic              last;
  logic              load;
  logic              is_data;
  logic [7:0]        sel_byte;

  assign total     = {1'b0, bnd_r.nbytes} + {2'b00, bnd_r.has_status};
  assign ptr_ext   = {1'b0, ptr_r};
  assign pop       = bnd_valid_r && (!out_valid_r || out_ready);
  assign last      = pop && (ptr_ext == (total - 3'd1));
  assign bnd_ready = !bnd_valid_r || last;
  assign load      = bnd_valid && bnd_ready;
  assign is_data   = ptr_r < bnd_r.nbytes;

  always_comb begin
    unique case (ptr_r)
      2'd0: sel_byte = bnd_r.byte0;
      2'd1: sel_byte = bnd_r.byte1;
      2'd2: sel_byte = bnd_r.byte2;
      2'd3: sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    bnd_valid_nxt = bnd_valid_r;
    ptr_nxt       = ptr_r;
    if (load) begin
      bnd_valid_nxt = 1'b1;
      ptr_nxt       = '0;
    end else if (last) begin
      bnd_valid_nxt = 1'b0;
    end else if (pop) begin
      ptr_nxt = ptr_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_valid_r <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bnd_valid_r <= bnd_valid_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bnd;
    end
    if (pop) begin
      if (is_data) begin
        data_r      <= sel_byte;
        is_status_r <= 1'b0;
        status_r    <= StOk;
        count_r     <= '0;
      end else begin
        data_r      <= 8'h00;
        is_status_r <= 1'b1;
        status_r    <= bnd_r.status;
        count_r     <= bnd_r.count;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = data_r;
  assign out_is_status  = is_status_r;
  assign out_status     = status_r;
  assign out_byte_count = count_r;
  assign out_final_item = is_status_r;

  `B64D_ASSERT_HOLDS(a_ptr_in_range, !bnd_valid_r || (ptr_ext < total), "result pointer past end of bundle")
  `B64D_ASSERT_HOLDS(a_status_is_last, !(pop && !is_data) || last, "status request not last of its bundle")
  `B64D_ASSERT_NEXT(a_drain_empties, last && !load, !bnd_valid_r, "bundle slot not freed after last request")

endmodule
`default_nettype wire

// File: rtl/base64_stream_decoder_unit.sv
// Streaming base64 decoder, standard alphabet with '=' padding.
// Input channel: one character per request on in_symbol, in_end_of_text
// high on the last character of a message. Config channel: cfg_data sets
// the per-message output byte limit; write it only while the block is idle.
// Result channel: decoded bytes one per request, then one status request
// (out_is_status and out_final_item high) carrying out_status and the
// message byte count in out_byte_count.
// The first result of a character passes from the input register through
// the bundle register to the output register, which drives out_valid.
// Throughput: one character per cycle, and one result per cycle on the
// output while out_ready stays high. A character that yields results
// waits in the input register while the previous character's results
// are still draining from the bundle register, so a group of bytes holds
// the decode stage; characters that yield nothing pass at full rate.
// Reset (rst_n low at a clock edge) empties all stages, clears the message
// state and sets the limit to its largest value.
// A stalled receiver holds the output register; back pressure reaches
// in_ready once the bundle and input registers are both occupied.
`default_nettype none
module base64_stream_decoder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_symbol,
  input  wire logic                        in_end_of_text,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [b64d_pkg::LimitW-1:0] cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_data_byte,
  output logic                             out_is_status,
  output logic [1:0]                       out_status,
  output logic [b64d_pkg::CountW-1:0]      out_byte_count,
  output logic                             out_final_item
);
  import b64d_pkg::*;

  logic         bnd_valid;
  logic         bnd_ready;
  b64d_bundle_t bnd;

  b64d_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_end_of_text (in_end_of_text),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .bnd_valid      (bnd_valid),
    .bnd            (bnd),
    .bnd_ready      (bnd_ready)
  );

  b64d_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .bnd_valid      (bnd_valid),
    .bnd            (bnd),
    .bnd_ready      (bnd_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_is_status  (out_is_status),
    .out_status     (out_status),
    .out_byte_count (out_byte_count),
    .out_final_item (out_final_item)
  );

endmodule
`default_nettype wire
